// ===== src/svm_pkg.sv =====
// shared constants, codes and control structs for the sample voice mixer
// depends on nothing; used by every mixer module but svm_ram, by scoped names
package svm_pkg;

  localparam int VOICES        = 8;
  localparam int SOUNDS        = 16;
  localparam int MAX_SOUND_LEN = 32768;

  localparam int SND_W    = 4;
  localparam int POS_W    = 15;
  localparam int LEN_W    = 16;
  localparam int SMP_W    = 16;
  localparam int VIDX_W   = 3;
  localparam int CNT_W    = 4;
  localparam int VOL_W    = 2;
  localparam int GAIN_W   = 10;
  localparam int PROD_W   = SMP_W + GAIN_W + 1;
  localparam int ACC_W    = PROD_W + $clog2(VOICES);
  localparam int STORE_AW = SND_W + POS_W;
  localparam int STORE_DEPTH = SOUNDS * MAX_SOUND_LEN;
  localparam int FRAC_BITS = 8;

  localparam logic [VOL_W-1:0]  VOL_MUTE  = 2'd0;
  localparam logic [VOL_W-1:0]  VOL_ONE   = 2'd1;
  localparam logic [VOL_W-1:0]  VOL_LOUD  = 2'd2;
  localparam logic [VOL_W-1:0]  VOL_RESET = VOL_LOUD;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 10'd256;
  localparam logic [GAIN_W-1:0] GAIN_BOOST = 10'd563;
  localparam logic [GAIN_W-1:0] GAIN_ZERO  = 10'd0;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_LENGTH = 2'd1,
    CMD_PLAY   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic exec;
    logic tick_start;
    logic issue;
    logic finish;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_voice;
  } dp_status_t;

endpackage

// ===== src/sample_voice_mixer_unit.sv =====
// top level of the sample voice mixer: controller plus datapath
// depends on svm_pkg, svm_ctrl, svm_datapath (and svm_ram through it)
// load, length and play items: result registered on accept, one item a cycle unless the output stalls
// tick items: an issue state per voice, then drain1, drain2 and finish, result registered in
// finish; at most one sample-store read per voice, and no other item is accepted meanwhile
// synchronous active-low reset clears voices, lengths and level (to loud);
// the sample store is not initialized and has no clearing pass
module sample_voice_mixer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [svm_pkg::VOL_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic [svm_pkg::SND_W-1:0]        in_sound_id,
  input  logic [svm_pkg::POS_W-1:0]        in_sample_index,
  input  logic signed [svm_pkg::SMP_W-1:0] in_sample_value,
  input  logic [svm_pkg::LEN_W-1:0]        in_sound_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [svm_pkg::SMP_W-1:0] out_frame_sample,
  output logic                             out_play_accepted,
  output logic [svm_pkg::VIDX_W-1:0]       out_voice_used,
  output logic [svm_pkg::CNT_W-1:0]        out_active_voices
);

  svm_pkg::ctl_cmd_t   cmd;
  svm_pkg::dp_status_t st;

  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  svm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_cmd            (in_cmd),
    .in_sound_id       (in_sound_id),
    .in_sample_index   (in_sample_index),
    .in_sample_value   (in_sample_value),
    .in_sound_length   (in_sound_length),
    .out_frame_sample  (out_frame_sample),
    .out_play_accepted (out_play_accepted),
    .out_voice_used    (out_voice_used),
    .out_active_voices (out_active_voices)
  );

endmodule

// ===== src/svm_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/svm_ctrl.sv =====
// controller of the mixer: handshakes, tick sequencing, output valid
// depends on svm_pkg
module svm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  svm_pkg::dp_status_t st,
  output svm_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ISSUE  = 5'b00010,
    S_DRAIN1 = 5'b00100,
    S_DRAIN2 = 5'b01000,
    S_FINISH = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        ready;
  logic        accept;
  logic        is_tick;

  assign ready   = (state_r == S_IDLE) && (!out_valid_r || !out_stall);
  assign accept  = ready && in_valid;
  assign is_tick = (svm_pkg::cmd_code_t'(in_cmd) == svm_pkg::CMD_TICK);

  always_comb begin
    cmd.exec       = accept && !is_tick;
    cmd.tick_start = accept && is_tick;
    cmd.issue      = (state_r == S_ISSUE);
    cmd.finish     = (state_r == S_FINISH);
    cmd.load_out   = cmd.exec || cmd.finish;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.tick_start) state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        if (st.last_voice) state_nxt = S_DRAIN1;
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !ready;
  assign out_valid = out_valid_r;

endmodule

// ===== src/svm_datapath.sv =====
// datapath of the mixer: voice state, length table, level, mix pipeline, result
// depends on svm_pkg and svm_ram (sample store)
module svm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  svm_pkg::ctl_cmd_t                   cmd,
  output svm_pkg::dp_status_t                 st,
  input  logic                                cfg_wr_en,
  input  logic [svm_pkg::VOL_W-1:0]           cfg_wr_data,
  input  logic [1:0]                          in_cmd,
  input  logic [svm_pkg::SND_W-1:0]           in_sound_id,
  input  logic [svm_pkg::POS_W-1:0]           in_sample_index,
  input  logic signed [svm_pkg::SMP_W-1:0]    in_sample_value,
  input  logic [svm_pkg::LEN_W-1:0]           in_sound_length,
  output logic signed [svm_pkg::SMP_W-1:0]    out_frame_sample,
  output logic                                out_play_accepted,
  output logic [svm_pkg::VIDX_W-1:0]          out_voice_used,
  output logic [svm_pkg::CNT_W-1:0]           out_active_voices
);

  localparam logic signed [svm_pkg::ACC_W-1:0] SAT_HI = 32767;
  localparam logic signed [svm_pkg::ACC_W-1:0] SAT_LO = -32768;
  localparam logic [svm_pkg::LEN_W-1:0] LEN_MAX = svm_pkg::LEN_W'(svm_pkg::MAX_SOUND_LEN);
  localparam logic [svm_pkg::VIDX_W-1:0] VIDX_LAST = svm_pkg::VIDX_W'(svm_pkg::VOICES - 1);

  logic                        vol_on;
  logic [svm_pkg::VOL_W-1:0]   level_r;
  logic                        active_r   [svm_pkg::VOICES];
  logic                        active_nxt [svm_pkg::VOICES];
  logic [svm_pkg::SND_W-1:0]   sound_r    [svm_pkg::VOICES];
  logic [svm_pkg::SND_W-1:0]   sound_nxt  [svm_pkg::VOICES];
  logic [svm_pkg::POS_W-1:0]   pos_r      [svm_pkg::VOICES];
  logic [svm_pkg::POS_W-1:0]   pos_nxt    [svm_pkg::VOICES];
  logic [svm_pkg::LEN_W-1:0]   length_r   [svm_pkg::SOUNDS];

  logic [svm_pkg::VIDX_W-1:0]  vcnt_r, vcnt_nxt;
  logic                        rd_hit_r, prod_hit_r;
  logic signed [svm_pkg::PROD_W-1:0] prod_r;
  logic signed [svm_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  logic signed [svm_pkg::SMP_W-1:0]  frame_r;
  logic                              accepted_r;
  logic [svm_pkg::VIDX_W-1:0]        used_r;
  logic [svm_pkg::CNT_W-1:0]         count_r;

  svm_pkg::cmd_code_t          op;
  logic [svm_pkg::SND_W-1:0]   len_addr;
  logic [svm_pkg::LEN_W-1:0]   len_rd;
  logic [svm_pkg::LEN_W-1:0]   len_sat;
  logic                        sid_ok;
  logic                        free_found;
  logic [svm_pkg::VIDX_W-1:0]  free_idx;
  logic                        play_ok;
  logic                        hit;
  logic [svm_pkg::LEN_W-1:0]   pos_step;
  logic [svm_pkg::GAIN_W-1:0]  gain;
  logic [svm_pkg::CNT_W-1:0]   count_nxt;
  logic signed [svm_pkg::ACC_W-1:0] q;
  logic signed [svm_pkg::SMP_W-1:0] frame_sat;

  logic                          ram_we;
  logic [svm_pkg::STORE_AW-1:0]  ram_waddr;
  logic [svm_pkg::STORE_AW-1:0]  ram_raddr;
  logic signed [svm_pkg::SMP_W-1:0] ram_rdata;

  assign vol_on = (level_r != svm_pkg::VOL_MUTE);
  assign op     = svm_pkg::cmd_code_t'(in_cmd);
  assign sid_ok = int'(in_sound_id) < svm_pkg::SOUNDS;

  assign len_addr = cmd.issue ? sound_r[vcnt_r] : in_sound_id;
  assign len_rd   = length_r[len_addr];
  assign len_sat  = (in_sound_length > LEN_MAX) ? LEN_MAX : in_sound_length;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = svm_pkg::VOICES - 1; v >= 0; v--) begin
      if (!active_r[v]) begin
        free_found = 1'b1;
        free_idx   = svm_pkg::VIDX_W'(v);
      end
    end
  end

  assign play_ok = cmd.exec && (op == svm_pkg::CMD_PLAY) && vol_on && sid_ok &&
                   (len_rd != '0) && free_found;

  assign hit      = active_r[vcnt_r] && ({1'b0, pos_r[vcnt_r]} < len_rd);
  assign pos_step = {1'b0, pos_r[vcnt_r]} + svm_pkg::LEN_W'(hit);

  always_comb begin
    for (int v = 0; v < svm_pkg::VOICES; v++) begin
      active_nxt[v] = active_r[v];
      sound_nxt[v]  = sound_r[v];
      pos_nxt[v]    = pos_r[v];
    end
    if (play_ok) begin
      active_nxt[free_idx] = 1'b1;
      sound_nxt[free_idx]  = in_sound_id;
      pos_nxt[free_idx]    = '0;
    end
    if (cmd.issue && active_r[vcnt_r]) begin
      if (pos_step < len_rd) begin
        pos_nxt[vcnt_r] = pos_step[svm_pkg::POS_W-1:0];
      end else begin
        active_nxt[vcnt_r] = 1'b0;
        pos_nxt[vcnt_r]    = '0;
      end
    end
  end

  always_comb begin
    count_nxt = '0;
    for (int v = 0; v < svm_pkg::VOICES; v++) begin
      count_nxt = count_nxt + svm_pkg::CNT_W'(active_nxt[v]);
    end
  end

  always_comb begin
    case (level_r)
      svm_pkg::VOL_ONE:  gain = svm_pkg::GAIN_UNITY;
      svm_pkg::VOL_LOUD: gain = svm_pkg::GAIN_BOOST;
      default:           gain = svm_pkg::GAIN_ZERO;
    endcase
  end

  always_comb begin
    vcnt_nxt = vcnt_r;
    if (cmd.tick_start) begin
      vcnt_nxt = '0;
    end else if (cmd.issue) begin
      vcnt_nxt = vcnt_r + 1'b1;
    end
  end

  assign st.last_voice = (vcnt_r == VIDX_LAST);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.tick_start) begin
      acc_nxt = '0;
    end else if (prod_hit_r) begin
      acc_nxt = acc_r + svm_pkg::ACC_W'(prod_r);
    end
  end

  // floor shift, then clamp to q1.15
  assign q = acc_r >>> svm_pkg::FRAC_BITS;
  always_comb begin
    if (q > SAT_HI) begin
      frame_sat = SAT_HI[svm_pkg::SMP_W-1:0];
    end else if (q < SAT_LO) begin
      frame_sat = SAT_LO[svm_pkg::SMP_W-1:0];
    end else begin
      frame_sat = q[svm_pkg::SMP_W-1:0];
    end
  end

  assign ram_we    = cmd.exec && (op == svm_pkg::CMD_LOAD) && sid_ok &&
                     (int'(in_sample_index) < svm_pkg::MAX_SOUND_LEN);
  assign ram_waddr = {in_sound_id, in_sample_index};
  assign ram_raddr = {sound_r[vcnt_r], pos_r[vcnt_r]};

  svm_ram #(
    .WIDTH (svm_pkg::SMP_W),
    .DEPTH (svm_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_sample_value),
    .rd_en   (cmd.issue && hit),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= svm_pkg::VOL_RESET;
      rd_hit_r   <= 1'b0;
      prod_hit_r <= 1'b0;
      vcnt_r     <= '0;
      for (int v = 0; v < svm_pkg::VOICES; v++) begin
        active_r[v] <= 1'b0;
        sound_r[v]  <= '0;
        pos_r[v]    <= '0;
      end
      for (int s = 0; s < svm_pkg::SOUNDS; s++) begin
        length_r[s] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        level_r <= cfg_wr_data;
      end
      rd_hit_r   <= cmd.issue && hit;
      prod_hit_r <= rd_hit_r;
      vcnt_r     <= vcnt_nxt;
      for (int v = 0; v < svm_pkg::VOICES; v++) begin
        active_r[v] <= active_nxt[v];
        sound_r[v]  <= sound_nxt[v];
        pos_r[v]    <= pos_nxt[v];
      end
      if (cmd.exec && (op == svm_pkg::CMD_LENGTH) && sid_ok) begin
        length_r[in_sound_id] <= len_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= svm_pkg::PROD_W'(ram_rdata) * svm_pkg::PROD_W'($signed({1'b0, gain}));
    acc_r  <= acc_nxt;
    if (cmd.load_out) begin
      frame_r    <= cmd.finish ? frame_sat : '0;
      accepted_r <= play_ok;
      used_r     <= play_ok ? free_idx : '0;
      count_r    <= count_nxt;
    end
  end

  assign out_frame_sample  = frame_r;
  assign out_play_accepted = accepted_r;
  assign out_voice_used    = used_r;
  assign out_active_voices = count_r;

endmodule

// ===== verif/svm_tb_pkg.sv =====
// scoreboard for the sample voice mixer testbench: item and result types,
// a copy of the voice, length and sample-word state, and the result check
// depends on svm_pkg
package svm_tb_pkg;
  import svm_pkg::*;

  typedef struct packed {
    cmd_code_t               cmd;
    logic [SND_W-1:0]        snd;
    logic [POS_W-1:0]        idx;
    logic signed [SMP_W-1:0] value;
    logic [LEN_W-1:0]        length;
  } mix_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] frame;
    logic                    accepted;
    logic [VIDX_W-1:0]       voice;
    logic [CNT_W-1:0]        active;
  } mix_result_t;

  class mix_scoreboard;
    logic [VOL_W-1:0]        level;
    bit                      voice_on [VOICES];
    logic [SND_W-1:0]        voice_snd [VOICES];
    int unsigned             voice_pos [VOICES];
    int unsigned             len_tab [SOUNDS];
    logic signed [SMP_W-1:0] pcm [STORE_DEPTH];
    bit                      pcm_ok [STORE_DEPTH];
    mix_result_t             due [$];
    int                      errors;

    function new();
      level = VOL_RESET;
      for (int v = 0; v < VOICES; v++) begin
        voice_on[v] = 1'b0;
        voice_snd[v] = '0;
        voice_pos[v] = 0;
      end
      for (int s = 0; s < SOUNDS; s++) begin
        len_tab[s] = 0;
      end
      errors = 0;
    endfunction

    function int unsigned word_key(input logic [SND_W-1:0] s, input int unsigned p);
      return int'(s) * MAX_SOUND_LEN + p;
    endfunction

    // first word that some voice will read at the next tick but was never loaded
    function bit missing_word(output logic [SND_W-1:0] s, output int unsigned p);
      s = '0;
      p = 0;
      for (int v = 0; v < VOICES; v++) begin
        if (voice_on[v] && voice_pos[v] < len_tab[voice_snd[v]] &&
            !pcm_ok[word_key(voice_snd[v], voice_pos[v])]) begin
          s = voice_snd[v];
          p = voice_pos[v];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_input(input mix_item_t it);
      mix_result_t      r;
      longint           gain;
      longint           acc;
      longint           q;
      logic [SND_W-1:0] s;
      int unsigned      p;
      int unsigned      n;
      int unsigned      key;
      int unsigned      busy;
      r.frame = '0;
      r.accepted = 1'b0;
      r.voice = '0;
      case (it.cmd)
        CMD_LOAD: begin
          key = word_key(it.snd, int'(it.idx));
          pcm[key] = it.value;
          pcm_ok[key] = 1'b1;
        end
        CMD_LENGTH: begin
          len_tab[it.snd] = it.length > MAX_SOUND_LEN ? MAX_SOUND_LEN : int'(it.length);
        end
        CMD_PLAY: begin
          if (level != VOL_MUTE && len_tab[it.snd] != 0) begin
            for (int v = 0; v < VOICES && !r.accepted; v++) begin
              if (!voice_on[v]) begin
                voice_on[v] = 1'b1;
                voice_snd[v] = it.snd;
                voice_pos[v] = 0;
                r.accepted = 1'b1;
                r.voice = VIDX_W'(v);
              end
            end
          end
        end
        default: begin
          gain = level == VOL_LOUD ? longint'(GAIN_BOOST) :
                 level == VOL_ONE ? longint'(GAIN_UNITY) : 0;
          acc = 0;
          for (int v = 0; v < VOICES; v++) begin
            if (voice_on[v]) begin
              s = voice_snd[v];
              p = voice_pos[v];
              n = len_tab[s];
              if (p < n) begin
                key = word_key(s, p);
                acc += longint'(pcm_ok[key] ? pcm[key] : 16'sd0) * gain;
                p++;
              end
              if (p < n) begin
                voice_pos[v] = p;
              end else begin
                voice_on[v] = 1'b0;
                voice_pos[v] = 0;
              end
            end
          end
          q = acc >>> FRAC_BITS;
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          r.frame = q[SMP_W-1:0];
        end
      endcase
      busy = 0;
      for (int v = 0; v < VOICES; v++) begin
        if (voice_on[v]) busy++;
      end
      r.active = CNT_W'(busy);
      due.push_back(r);
    endfunction

    task flag(input string what);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check(input mix_result_t got);
      mix_result_t want;
      if (due.size() == 0) begin
        flag($sformatf("result with none outstanding, frame %0d", got.frame));
        return;
      end
      want = due.pop_front();
      if (got.frame !== want.frame)
        flag($sformatf("frame_sample %0d, wanted %0d", got.frame, want.frame));
      if (got.accepted !== want.accepted)
        flag($sformatf("play_accepted %b, wanted %b", got.accepted, want.accepted));
      if (got.voice !== want.voice)
        flag($sformatf("voice_used %0d, wanted %0d", got.voice, want.voice));
      if (got.active !== want.active)
        flag($sformatf("active_voices %0d, wanted %0d", got.active, want.active));
    endtask
  endclass

endpackage

// ===== verif/sample_voice_mixer_unit_tb.sv =====
// top of the sample voice mixer testbench: clock, reset, item and stall
// generation with random gaps, level changes between phases, result monitor
// depends on svm_pkg, svm_tb_pkg and the sample_voice_mixer_unit rtl
module sample_voice_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;
  import svm_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 2000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 6;
  localparam logic [VOL_W-1:0] VOL_SPARE = 2'd3;
  localparam logic [VOL_W-1:0] LEVEL_PLAN [PHASES] =
    '{VOL_ONE, VOL_MUTE, VOL_SPARE, VOL_LOUD, VOL_ONE, VOL_LOUD};
  localparam int PHASE_ITEMS [PHASES] = '{350, 200, 250, 400, 350, 350};

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [VOL_W-1:0]        cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_cmd;
  logic [SND_W-1:0]        in_sound_id;
  logic [POS_W-1:0]        in_sample_index;
  logic signed [SMP_W-1:0] in_sample_value;
  logic [LEN_W-1:0]        in_sound_length;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] out_frame_sample;
  logic                    out_play_accepted;
  logic [VIDX_W-1:0]       out_voice_used;
  logic [CNT_W-1:0]        out_active_voices;

  mix_scoreboard sb;
  bit            calm;
  int unsigned   cycles = 0;
  int unsigned   sent = 0;

  sample_voice_mixer_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_sound_id       (in_sound_id),
    .in_sample_index   (in_sample_index),
    .in_sample_value   (in_sample_value),
    .in_sound_length   (in_sound_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_sample  (out_frame_sample),
    .out_play_accepted (out_play_accepted),
    .out_voice_used    (out_voice_used),
    .out_active_voices (out_active_voices)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check('{out_frame_sample, out_play_accepted, out_voice_used, out_active_voices});
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin : stall_gen
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = pause_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic mix_item_t mk(input cmd_code_t c, input logic [SND_W-1:0] s,
                                   input logic [POS_W-1:0] i,
                                   input logic signed [SMP_W-1:0] v,
                                   input logic [LEN_W-1:0] n);
    mix_item_t it;
    it.cmd = c;
    it.snd = s;
    it.idx = i;
    it.value = v;
    it.length = n;
    return it;
  endfunction

  function automatic logic [SND_W-1:0] rand_sound();
    if ($urandom_range(0, 99) < 70) return SND_W'($urandom_range(0, 5));
    return SND_W'($urandom_range(0, SOUNDS - 1));
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 6) return SMP_W'($urandom_range(0, 4000) - 2000);
    return SMP_W'($urandom());
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 80) return LEN_W'($urandom_range(1, 40));
    if (r < 87) return LEN_W'(MAX_SOUND_LEN);
    if (r < 94) return LEN_W'($urandom_range(MAX_SOUND_LEN + 1, 65535));
    return LEN_W'($urandom_range(41, 2000));
  endfunction

  function automatic mix_item_t noise();
    return mk(cmd_code_t'($urandom_range(0, 3)), rand_sound(), POS_W'($urandom()),
              SMP_W'($urandom()), LEN_W'($urandom()));
  endfunction

  task automatic send(input mix_item_t it);
    int n;
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_sound_id     <= it.snd;
    in_sample_index <= it.idx;
    in_sample_value <= it.value;
    in_sound_length <= it.length;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(it);
    sent++;
    n = pause_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // load any word a playing voice is about to read, then mix a frame
  task automatic send_tick();
    logic [SND_W-1:0] s;
    int unsigned      p;
    mix_item_t        it;
    while (sb.missing_word(s, p)) begin
      it = noise();
      it.cmd = CMD_LOAD;
      it.snd = s;
      it.idx = p[POS_W-1:0];
      it.value = rand_sample();
      send(it);
    end
    it = noise();
    it.cmd = CMD_TICK;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [VOL_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.level = v;
  endtask

  task automatic directed();
    send(mk(CMD_TICK, 4'd0, '0, '0, '0));
    send(mk(CMD_PLAY, 4'd0, '0, '0, '0));
    send(mk(CMD_LENGTH, 4'd1, '0, '0, 16'hFFFF));
    send(mk(CMD_LENGTH, 4'd1, '0, '0, 16'd2));
    send(mk(CMD_LOAD, 4'd1, 15'd0, 16'sh7FFF, '0));
    send(mk(CMD_LOAD, 4'd1, 15'd1, 16'sh8000, '0));
    send(mk(CMD_LENGTH, 4'd2, '0, '0, 16'd1));
    send(mk(CMD_LOAD, 4'd2, 15'd0, -16'sd1, '0));
    send(mk(CMD_PLAY, 4'd1, '0, '0, '0));
    send(mk(CMD_PLAY, 4'd2, '0, '0, '0));
    send_tick();
    send_tick();
    // fill every voice, the last play finds none free
    send(mk(CMD_LENGTH, 4'd15, '0, '0, 16'd5));
    repeat (VOICES + 1) send(mk(CMD_PLAY, 4'd15, '0, '0, '0));
    send_tick();
    // length cut to zero under playing voices
    send(mk(CMD_LENGTH, 4'd15, '0, '0, '0));
    send_tick();
  endtask

  task automatic run_mix(input int count);
    int          r;
    int          k;
    int unsigned stop;
    mix_item_t   it;
    k = 0;
    stop = sent + count;
    while (sent < stop) begin
      if (k % 120 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 299) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 44) begin
        send_tick();
      end else begin
        it = noise();
        if (r < 66) begin
          it.cmd = CMD_PLAY;
        end else if (r < 86) begin
          it.cmd = CMD_LOAD;
          it.idx = $urandom_range(0, 99) < 70 ? POS_W'($urandom_range(0, 63))
                                                : POS_W'($urandom());
          it.value = rand_sample();
        end else begin
          it.cmd = CMD_LENGTH;
          it.length = rand_len();
        end
        send(it);
      end
      k++;
    end
    calm = 1'b0;
  endtask

  initial begin : main_seq
    sb = new();
    calm = 1'b0;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_LOAD;
    in_sound_id     <= '0;
    in_sample_index <= '0;
    in_sample_value <= '0;
    in_sound_length <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      write_level(LEVEL_PLAN[ph]);
      run_mix(PHASE_ITEMS[ph]);
      drain();
    end
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
